// ===== design/ptw_pkg.sv =====
// ptw_pkg: shared widths, constants and codes for the page table walker.
// No dependencies; imported by ptw_addr_unit and page_table_walker_core.
package ptw_pkg;

  // Field widths
  localparam int RootW      = 52;
  localparam int WordAddrW  = 12;
  localparam int WordW      = 64;
  localparam int VaW        = 48;
  localparam int PaW        = 52;
  localparam int LimW       = 53;
  localparam int FaultW     = 2;
  localparam int LevelW     = 2;
  localparam int IdxBits    = 9;
  // word index = base / 8 + level index, one guard bit for the carry
  localparam int WideIdxW   = PaW - 3 + 1;

  // Store depth default
  localparam int StoreWordsDef = 4096;

  // Highest table base accepted is below this mapping limit
  localparam logic [PaW-1:0] MapLimit = PaW'((64'd1 << 39) - (64'd1 << 12));

  // Entry bits
  localparam int PresentBit = 0;
  localparam int LargeBit   = 7;
  localparam int PageShift  = 12;

  // Walk starts at the top level
  localparam logic [LevelW-1:0] TopLevel = 2'd3;

  // Commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  // Fault kinds
  localparam logic [FaultW-1:0] FAULT_NONE   = 2'd0;
  localparam logic [FaultW-1:0] FAULT_LIMIT  = 2'd1;
  localparam logic [FaultW-1:0] FAULT_ABSENT = 2'd2;

  // Offset mask below the shift of a level (level 0 is the 4K level)
  function automatic logic [PaW-1:0] low_mask(input logic [LevelW-1:0] level);
    logic [PaW-1:0] m;
    case (level)
      2'd0:    m = PaW'((64'd1 << 12) - 64'd1);
      2'd1:    m = PaW'((64'd1 << 21) - 64'd1);
      2'd2:    m = PaW'((64'd1 << 30) - 64'd1);
      2'd3:    m = PaW'((64'd1 << 39) - 64'd1);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== design/ptw_ram.sv =====
// ptw_ram: generic single-port RAM with registered read data.
// No dependencies; holds the table store of the walker.
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write or one read per cycle, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/ptw_addr_unit.sv =====
// ptw_addr_unit: shared table index unit, reused once per walk level.
// Depends on ptw_pkg. Forms the store word index and the range fault.
module ptw_addr_unit #(
  parameter int STORE_WORDS = ptw_pkg::StoreWordsDef
) (
  input  logic [ptw_pkg::PaW-1:0]          base_i,
  input  logic [ptw_pkg::VaW-1:0]          va_i,
  input  logic [ptw_pkg::LevelW-1:0]       level_i,
  output logic [$clog2(STORE_WORDS)-1:0]   word_index_o,
  output logic                             fault_o
);
  import ptw_pkg::*;

  localparam int AW = $clog2(STORE_WORDS);

  logic [IdxBits-1:0]  level_idx;
  logic [WideIdxW-1:0] wide_idx;

  // Nine index bits taken at the shift of the current level
  always_comb begin
    case (level_i)
      2'd0:    level_idx = va_i[20:12];
      2'd1:    level_idx = va_i[29:21];
      2'd2:    level_idx = va_i[38:30];
      2'd3:    level_idx = va_i[47:39];
      default: level_idx = '0;
    endcase
  end

  // Word index = base / 8 + level index
  assign wide_idx = {1'b0, base_i[PaW-1:3]} + WideIdxW'(level_idx);

  // Fault on base beyond the mapping limit or index beyond the store
  assign fault_o = (base_i >= MapLimit) || (wide_idx >= WideIdxW'(STORE_WORDS));

  assign word_index_o = wide_idx[AW-1:0];

endmodule

// ===== design/page_table_walker_core.sv =====
// page_table_walker_core: four-level page table walker, top level.
// Depends on ptw_pkg, ptw_ram and ptw_addr_unit.
//
//   channel  | direction | handshake           | carries
//   ---------+-----------+---------------------+-----------------------------------
//   in_      | input     | in_valid/in_ready   | command, word address/data, VA
//   out_     | output    | out_valid/out_ready | fault kind, PA, page end, size
//   cfg_     | input     | cfg_wr_en           | table_root
//
// A load is written to the store as it is accepted; loads can follow back to back.
// A translate steps through S_LOOKUP and S_ENTRY once per level read, then S_RESULT:
// S_LOOKUP forms the index and issues the RAM read, S_ENTRY examines the entry;
// a table beyond the limit or the store ends the walk straight from S_LOOKUP.
// rst_n is synchronous, active low; the store is not cleared by reset.
// in_ready is low while a walk runs; a finished result waits in the output
// register, and a following result waits until that one is taken.
module page_table_walker_core #(
  parameter int STORE_WORDS = ptw_pkg::StoreWordsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [ptw_pkg::WordAddrW-1:0] in_word_address,
  input  logic [ptw_pkg::WordW-1:0]    in_word_data,
  input  logic [ptw_pkg::VaW-1:0]      in_virtual_address,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ptw_pkg::FaultW-1:0]   out_fault_kind,
  output logic [ptw_pkg::PaW-1:0]      out_phys_addr,
  output logic [ptw_pkg::LimW-1:0]     out_page_end,
  output logic [ptw_pkg::LevelW-1:0]   out_page_size_code,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [ptw_pkg::RootW-1:0]    cfg_wr_data
);
  import ptw_pkg::*;

  localparam int AW  = $clog2(STORE_WORDS);
  localparam int LdW = (AW + 1 > WordAddrW) ? AW + 1 : WordAddrW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_ENTRY,
    S_RESULT
  } state_t;

  state_t              state_r, state_nxt;
  logic [RootW-1:0]    table_root_r, table_root_nxt;
  logic [VaW-1:0]      va_r, va_nxt;
  logic [PaW-1:0]      base_r, base_nxt;
  logic [LevelW-1:0]   level_r, level_nxt;
  logic [FaultW-1:0]   pend_fault_r, pend_fault_nxt;
  logic [PaW-1:0]      pend_pa_r, pend_pa_nxt;
  logic [LimW-1:0]     pend_lim_r, pend_lim_nxt;
  logic [LevelW-1:0]   pend_code_r, pend_code_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [FaultW-1:0]   out_fault_r, out_fault_nxt;
  logic [PaW-1:0]      out_pa_r, out_pa_nxt;
  logic [LimW-1:0]     out_lim_r, out_lim_nxt;
  logic [LevelW-1:0]   out_code_r, out_code_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [WordW-1:0]    ram_rdata;
  logic [AW-1:0]       au_word_index;
  logic                au_fault;
  logic                load_ok;
  logic [PaW-1:0]      low;
  logic [PaW-1:0]      leaf_pa;
  logic [LimW-1:0]     leaf_lim;

  // Table store
  ptw_ram #(
    .WIDTH (WordW),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_word_data),
    .rdata (ram_rdata)
  );

  // Shared index unit, one level per pass
  ptw_addr_unit #(
    .STORE_WORDS (STORE_WORDS)
  ) u_addr (
    .base_i       (base_r),
    .va_i         (va_r),
    .level_i      (level_r),
    .word_index_o (au_word_index),
    .fault_o      (au_fault)
  );

  // Loads beyond the store are dropped
  assign load_ok = LdW'(in_word_address) < LdW'(STORE_WORDS);

  // Leaf translation from the entry just read
  assign low      = low_mask(level_r);
  assign leaf_pa  = (ram_rdata[PaW-1:0] & ~low) | ({{(PaW-VaW){1'b0}}, va_r} & low);
  assign leaf_lim = {1'b0, leaf_pa | low} + LimW'(1);

  assign in_ready = (state_r == S_IDLE);

  // Walk sequencer
  always_comb begin
    state_nxt      = state_r;
    table_root_nxt = table_root_r;
    va_nxt         = va_r;
    base_nxt       = base_r;
    level_nxt      = level_r;
    pend_fault_nxt = pend_fault_r;
    pend_pa_nxt    = pend_pa_r;
    pend_lim_nxt   = pend_lim_r;
    pend_code_nxt  = pend_code_r;
    out_valid_nxt  = out_valid_r;
    out_fault_nxt  = out_fault_r;
    out_pa_nxt     = out_pa_r;
    out_lim_nxt    = out_lim_r;
    out_code_nxt   = out_code_r;
    ram_we         = 1'b0;
    ram_addr       = AW'(in_word_address);

    if (cfg_wr_en) begin
      table_root_nxt = cfg_wr_data;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_XLATE) begin
            va_nxt    = in_virtual_address;
            base_nxt  = table_root_r;
            level_nxt = TopLevel;
            state_nxt = S_LOOKUP;
          end else begin
            ram_we = load_ok;
          end
        end
      end
      S_LOOKUP: begin
        ram_addr = au_word_index;
        if (au_fault) begin
          pend_fault_nxt = FAULT_LIMIT;
          pend_pa_nxt    = '0;
          pend_lim_nxt   = '0;
          pend_code_nxt  = '0;
          state_nxt      = S_RESULT;
        end else begin
          state_nxt = S_ENTRY;
        end
      end
      S_ENTRY: begin
        if (!ram_rdata[PresentBit]) begin
          pend_fault_nxt = FAULT_ABSENT;
          pend_pa_nxt    = '0;
          pend_lim_nxt   = '0;
          pend_code_nxt  = '0;
          state_nxt      = S_RESULT;
        end else if (ram_rdata[LargeBit] || level_r == '0) begin
          pend_fault_nxt = FAULT_NONE;
          pend_pa_nxt    = leaf_pa;
          pend_lim_nxt   = leaf_lim;
          pend_code_nxt  = level_r;
          state_nxt      = S_RESULT;
        end else begin
          // next table base from entry bits 51..12
          base_nxt  = {ram_rdata[PaW-1:PageShift], {PageShift{1'b0}}};
          level_nxt = level_r - LevelW'(1);
          state_nxt = S_LOOKUP;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_fault_nxt = pend_fault_r;
          out_pa_nxt    = pend_pa_r;
          out_lim_nxt   = pend_lim_r;
          out_code_nxt  = pend_code_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, control and registered outputs
  always_ff @(posedge clk) begin
    va_r         <= va_nxt;
    base_r       <= base_nxt;
    level_r      <= level_nxt;
    pend_fault_r <= pend_fault_nxt;
    pend_pa_r    <= pend_pa_nxt;
    pend_lim_r   <= pend_lim_nxt;
    pend_code_r  <= pend_code_nxt;
    out_fault_r  <= out_fault_nxt;
    out_pa_r     <= out_pa_nxt;
    out_lim_r    <= out_lim_nxt;
    out_code_r   <= out_code_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      table_root_r <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      table_root_r <= table_root_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fault_kind     = out_fault_r;
  assign out_phys_addr      = out_pa_r;
  assign out_page_end       = out_lim_r;
  assign out_page_size_code = out_code_r;

endmodule

// ===== tb/ptw_tb_pkg.sv =====
// ptw_tb_pkg: translation record and the scoreboard used by the page table walker bench.
// Depends on ptw_pkg for widths, entry bits, fault kinds and command codes.
package ptw_tb_pkg;
  import ptw_pkg::*;

  localparam int          TableWords = StoreWordsDef;
  localparam logic [63:0] AddrMask   = 64'h000f_ffff_ffff_ffff;
  localparam logic [63:0] FrameMask  = 64'h000f_ffff_ffff_f000;

  // One translation outcome as it shows on the result channel
  typedef struct {
    logic [FaultW-1:0] fault;
    logic [PaW-1:0]    pa;
    logic [LimW-1:0]   lim;
    logic [LevelW-1:0] size;
  } xlate_t;

  class xlate_scoreboard;
    logic [WordW-1:0] table_copy [TableWords];
    bit               written [TableWords];
    logic [RootW-1:0] root;
    xlate_t           pending_xlates [$];
    int               mismatch_count;

    function new();
      root = '0;
      mismatch_count = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    // Walk the shadow tables for va. Returns the index of the first word the walk
    // would read before it was ever loaded, or -1 when res holds the outcome.
    function int walk_tables(input logic [VaW-1:0] va, output xlate_t res);
      logic [63:0] base, widx, entry, low, pa, lim, va64;
      int          shift;
      res       = '{default: '0};
      res.fault = FAULT_NONE;
      va64      = 64'(va);
      base      = 64'(root);
      for (int lvl = TopLevel; lvl >= 0; lvl--) begin
        shift = PageShift + IdxBits * lvl;
        widx  = (base >> 3) + ((va64 >> shift) & 64'h1ff);
        // table base past the mapping limit, or entry beyond the store
        if (base >= 64'(MapLimit) || widx >= 64'(TableWords)) begin
          res.fault = FAULT_LIMIT;
          return -1;
        end
        if (!written[widx]) return int'(widx);
        entry = table_copy[widx];
        if (!entry[PresentBit]) begin
          res.fault = FAULT_ABSENT;
          return -1;
        end
        // large page on any level, or the 4K leaf
        if (entry[LargeBit] || lvl == 0) begin
          low      = (64'd1 << shift) - 64'd1;
          pa       = (entry & AddrMask & ~low) | (va64 & low);
          lim      = (pa | low) + 64'd1;
          res.pa   = pa[PaW-1:0];
          res.lim  = lim[LimW-1:0];
          res.size = LevelW'(lvl);
          return -1;
        end
        base = entry & FrameMask;
      end
      return -1;
    endfunction

    // Accepted input transaction: loads update the shadow store, translates queue a result
    function void note_command(input logic cmd, input logic [WordAddrW-1:0] waddr,
                               input logic [WordW-1:0] wdata, input logic [VaW-1:0] va);
      xlate_t res;
      if (cmd == CMD_LOAD) begin
        if (int'(waddr) < TableWords) begin
          table_copy[waddr] = wdata;
          written[waddr]    = 1'b1;
        end
      end else begin
        void'(walk_tables(va, res));
        pending_xlates.push_back(res);
      end
    endfunction

    function int outstanding();
      return pending_xlates.size();
    endfunction

    task report(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatch_count++;
    endtask

    // Accepted result transaction against the oldest outstanding translate
    task check_xlate(input logic [FaultW-1:0] fault, input logic [PaW-1:0] pa,
                     input logic [LimW-1:0] lim, input logic [LevelW-1:0] size);
      xlate_t want;
      if (pending_xlates.size() == 0) begin
        report($sformatf("result with no translate outstanding (fault_kind %0d)", fault));
        return;
      end
      want = pending_xlates.pop_front();
      if (fault !== want.fault)
        report($sformatf("fault_kind got %0d want %0d", fault, want.fault));
      if (pa !== want.pa)
        report($sformatf("phys_addr got %h want %h", pa, want.pa));
      if (lim !== want.lim)
        report($sformatf("page_end got %h want %h", lim, want.lim));
      if (size !== want.size)
        report($sformatf("page_size_code got %0d want %0d", size, want.size));
    endtask
  endclass

endpackage

// ===== tb/testbench.sv =====
// testbench: drives page_table_walker_core with table loads and translates, checks results.
// Depends on ptw_pkg and ptw_tb_pkg (shadow tables and result scoreboard).
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ptw_pkg::*;
  import ptw_tb_pkg::*;

  typedef enum logic [2:0] {ENT_TABLE, ENT_LEAF, ENT_ABSENT, ENT_FAR, ENT_HIGH} entry_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_LONG} rx_mode_t;

  localparam int          FrameCount = TableWords / 512;
  localparam logic [39:0] LimitFrame = 40'(MapLimit >> PageShift);

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_command = CMD_LOAD;
  logic [WordAddrW-1:0] in_word_address = '0;
  logic [WordW-1:0]     in_word_data = '0;
  logic [VaW-1:0]       in_virtual_address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [FaultW-1:0]    out_fault_kind;
  logic [PaW-1:0]       out_phys_addr;
  logic [LimW-1:0]      out_page_end;
  logic [LevelW-1:0]    out_page_size_code;
  logic                 cfg_wr_en = 1'b0;
  logic [RootW-1:0]     cfg_wr_data = '0;

  xlate_scoreboard sb;
  int              burst_left = 0;
  int              items_sent = 0;
  logic [VaW-1:0]  mapped_va [$];

  page_table_walker_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_word_address     (in_word_address),
    .in_word_data        (in_word_data),
    .in_virtual_address  (in_virtual_address),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_fault_kind      (out_fault_kind),
    .out_phys_addr       (out_phys_addr),
    .out_page_end        (out_page_end),
    .out_page_size_code  (out_page_size_code),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: check every accepted transaction; stall in a random mode: always ready, coin toss or long holds
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_cycle = 0;
  int       rx_hold = 0;
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_ready)
      sb.check_xlate(out_fault_kind, out_phys_addr, out_page_end, out_page_size_code);
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_mode = rx_mode_t'($urandom_range(0, 2));
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        default: begin
          if (rx_hold > 0) begin
            rx_hold--;
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 24);
          end
        end
      endcase
    end
  end

  function automatic logic [VaW-1:0] rand_va();
    return VaW'({$urandom, $urandom});
  endfunction

  // Table entry of the given kind; pointer kinds keep random flag and upper bits
  function automatic logic [WordW-1:0] make_entry(input entry_kind_t kind, input int lvl);
    logic [WordW-1:0] e;
    logic [39:0]      frame;
    e = {$urandom, $urandom};
    case (kind)
      ENT_LEAF: begin
        e[PresentBit] = 1'b1;
        if (lvl > 0) e[LargeBit] = 1'b1;
      end
      ENT_ABSENT: e[PresentBit] = 1'b0;
      default: begin
        if (kind == ENT_TABLE) begin
          frame = 40'($urandom_range(0, FrameCount - 1));
        end else if (kind == ENT_FAR) begin
          // first frame past the store, or any frame past the store below the mapping limit
          frame = ($urandom_range(0, 3) == 0) ? 40'(FrameCount) :
                  40'($urandom_range(FrameCount, 32'(LimitFrame) - 1));
        end else begin
          frame = 40'({$urandom, $urandom});
          if ($urandom_range(0, 3) == 0) frame = LimitFrame;
          else if (frame < LimitFrame) frame[39] = 1'b1;
        end
        e[51:12]      = frame;
        e[LargeBit]   = 1'b0;
        e[PresentBit] = 1'b1;
      end
    endcase
    return e;
  endfunction

  // One input transaction, sent in bursts with random gaps in between
  task automatic send_item(input logic cmd, input logic [WordAddrW-1:0] waddr,
                           input logic [WordW-1:0] wdata, input logic [VaW-1:0] va);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid           <= 1'b1;
    in_command         <= cmd;
    in_word_address    <= waddr;
    in_word_data       <= wdata;
    in_virtual_address <= va;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(cmd, waddr, wdata, va);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_load(input logic [WordAddrW-1:0] waddr, input logic [WordW-1:0] wdata);
    send_item(CMD_LOAD, waddr, wdata, rand_va());
  endtask

  // Translate; any never-loaded word on the walk gets a random entry first
  task automatic send_translate(input logic [VaW-1:0] va);
    xlate_t      probe;
    int          hole;
    int          pick;
    entry_kind_t kind;
    hole = sb.walk_tables(va, probe);
    while (hole >= 0) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 5) ? ENT_TABLE : (pick < 8) ? ENT_LEAF : (pick == 8) ? ENT_ABSENT : ENT_FAR;
      send_load(WordAddrW'(hole), make_entry(kind, $urandom_range(0, 3)));
      hole = sb.walk_tables(va, probe);
    end
    send_item(CMD_XLATE, WordAddrW'($urandom), {$urandom, $urandom}, va);
  endtask

  // Load a chain of depth entries along the walk of va, the last one of kind ending
  task automatic plant_walk(input logic [VaW-1:0] va, input int depth,
                            input entry_kind_t ending);
    logic [63:0]      base, widx;
    logic [WordW-1:0] entry;
    int               lvl;
    base = 64'(sb.root);
    for (lvl = TopLevel; lvl >= 4 - depth; lvl--) begin
      widx = (base >> 3) + ((64'(va) >> (PageShift + IdxBits * lvl)) & 64'h1ff);
      if (base >= 64'(MapLimit) || widx >= 64'(TableWords)) return;
      entry = make_entry((lvl == 4 - depth) ? ending : ENT_TABLE, lvl);
      send_load(widx[WordAddrW-1:0], entry);
      base = entry & FrameMask;
    end
  endtask

  // Root is only changed with the walker idle and nothing outstanding
  task automatic write_root(input logic [RootW-1:0] value);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.root = value;
  endtask

  // Mostly well-formed walks with random content, plus revisits and noise
  task automatic run_random(input int count);
    int             stop;
    int             pick;
    int             depth;
    entry_kind_t    ending;
    logic [VaW-1:0] va;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      va   = rand_va();
      if (pick < 55) begin
        depth  = $urandom_range(1, 4);
        pick   = $urandom_range(0, 9);
        ending = (pick < 7) ? ENT_LEAF : (pick == 7) ? ENT_ABSENT :
                 (pick == 8) ? ENT_FAR : ENT_HIGH;
        plant_walk(va, depth, ending);
        send_translate(va);
        mapped_va.push_back(va);
        if (mapped_va.size() > 64) void'(mapped_va.pop_front());
      end else if (pick < 70 && mapped_va.size() > 0) begin
        // a mapped va again, its low 21 bits randomly flipped or kept
        va = mapped_va[$urandom_range(0, mapped_va.size() - 1)] ^
             (VaW'($urandom) & 48'h1f_ffff & {VaW{1'($urandom_range(0, 3) != 0)}});
        send_translate(va);
      end else if (pick < 85) begin
        send_load(WordAddrW'($urandom), {$urandom, $urandom});
      end else begin
        send_translate(va);
      end
    end
  endtask

  // Main sequence
  initial begin
    logic [VaW-1:0] va;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: store extremes, absent top entry, 512G page at all-ones address
    send_load(12'hfff, '1);
    send_load(12'h000, '0);
    send_translate('0);
    send_load(12'h1ff, '1);
    send_translate('1);
    // 4K, 2M and 1G pages, pointer past the mapping limit, pointer past the store
    va = rand_va(); plant_walk(va, 4, ENT_LEAF); send_translate(va);
    va = rand_va(); plant_walk(va, 3, ENT_LEAF); send_translate(va);
    va = rand_va(); plant_walk(va, 2, ENT_LEAF); send_translate(va);
    va = rand_va(); plant_walk(va, 1, ENT_HIGH); send_translate(va);
    va = rand_va(); plant_walk(va, 1, ENT_FAR);  send_translate(va);
    // root with every bit set
    write_root('1);
    send_translate(rand_va());

    // Random phases over several roots
    write_root(RootW'($urandom_range(0, FrameCount - 1)) << PageShift);
    run_random(300);
    write_root((RootW'($urandom_range(0, TableWords - 512)) << 3) |
               RootW'($urandom_range(0, 7)));
    run_random(300);
    // last store word as the first top-level entry
    write_root(RootW'((TableWords - 1) * 8) | RootW'($urandom_range(0, 7)));
    run_random(50);
    write_root(MapLimit - RootW'(8));
    run_random(40);
    write_root(MapLimit);
    run_random(40);
    write_root(RootW'({$urandom, $urandom}));
    run_random(40);
    write_root('0);
    run_random(300);
    write_root(RootW'($urandom_range(0, FrameCount - 1)) << PageShift);
    run_random(150);

    // Drain
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog: reports a mismatch and stops a run that hangs
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
